// File: design/crc8dfc_pkg.sv
`default_nettype none

package crc8dfc_pkg;

	localparam int unsigned MAX_WORDS = 16;
	localparam int unsigned COUNT_CAP = 16;

	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [7:0] CRC_INIT = 8'h00;
	localparam logic [7:0] CRC_TOP  = 8'h80;

	localparam logic [4:0] COUNT_MAX = 5'(COUNT_CAP);
	localparam logic [4:0] WORDS_MAX = 5'((MAX_WORDS < COUNT_CAP) ? MAX_WORDS : COUNT_CAP);

	localparam logic [0:0] REG_WORDS_PER_RESPONSE = 1'b0;

	typedef enum logic [1:0] {
		PH_HIGH = 2'd0,
		PH_LOW  = 2'd1,
		PH_CRC  = 2'd2,
		PH_SPARE = 2'd3
	} phase_t;

	typedef struct packed {
		logic [4:0]  error_count;
		logic        all_ok;
		logic        word_last;
		logic [3:0]  store_index;
		logic        crc_ok;
		logic [15:0] data_word;
	} result_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			if ((c & CRC_TOP) != 8'h00) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: design/word_crc8_deframe_checker_unit.sv
// A word's result is registered in the output buffer when its CRC byte is taken; one byte
// per cycle is taken while the spare entry is empty; CRC, compare and counters add no stall.
// A two-entry output buffer keeps the slave side open while one result waits to be taken.
// Reset (arst_n low) clears the word phase, the counters and the buffer, and sets
// words_per_response to 6.
`default_nettype none

module word_crc8_deframe_checker_unit
	import crc8dfc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] rx_byte
	input  wire logic        s_tuser,  // [0] frame_start
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // [15:0] data_word, [19:16] store_index, [24:20] error_count
	output logic [1:0]       m_tuser,  // [0] crc_ok, [1] all_ok
	output logic             m_tlast,  // word_last
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [4:0] words_per_response_q;
	logic       in_accept;
	logic       res_valid;
	result_t    res;
	result_t    out_res;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_WORDS_PER_RESPONSE) ? {27'd0, words_per_response_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_per_response_q <= 5'd6;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == REG_WORDS_PER_RESPONSE) begin
			words_per_response_q <= pwdata[4:0];
		end
	end

	assign in_accept = s_tvalid && s_tready;

	crc8dfc_word_track u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_accept),
		.rx_byte     (s_tdata),
		.frame_start (s_tuser),
		.words_cfg   (words_per_response_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	crc8dfc_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_res    (res),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {7'd0, out_res.error_count, out_res.store_index, out_res.data_word};
	assign m_tuser = {out_res.all_ok, out_res.crc_ok};
	assign m_tlast = out_res.word_last;

	// The spare buffer entry is only ever occupied behind a full main entry.
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("spare entry holds a result while the output is empty");

	// A clean response can only be flagged on its last word, with no failures.
	a_all_ok_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast && m_tuser[0] && (m_tdata[24:20] == 5'd0))
		else $error("all_ok raised on a word that is not a clean last word");

	// A failing word takes no packed position and is always counted.
	a_fail_counted: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> (m_tdata[19:16] == 4'd0) && (m_tdata[24:20] != 5'd0))
		else $error("failing word has a store position or was not counted");

endmodule

`default_nettype wire

// File: design/crc8dfc_word_track.sv
`default_nettype none

module crc8dfc_word_track
	import crc8dfc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [7:0] rx_byte,
	input  wire logic       frame_start,
	input  wire logic [4:0] words_cfg,
	output logic            res_valid,
	output result_t         res
);

	phase_t     phase_q;
	logic [7:0] crc_q;
	logic [7:0] high_q;
	logic [7:0] low_q;
	logic [4:0] word_cnt_q;
	logic [4:0] good_cnt_q;
	logic [4:0] fail_cnt_q;

	phase_t     phase_cur;
	logic [4:0] word_cur;
	logic [4:0] good_cur;
	logic [4:0] fail_cur;
	logic [4:0] word_nxt;
	logic [4:0] good_nxt;
	logic [4:0] fail_nxt;
	logic [4:0] words_eff;
	logic       ok;
	logic       last;
	logic       is_crc;

	// A frame start restarts the word before the byte is taken.
	assign phase_cur = frame_start ? PH_HIGH : phase_q;
	assign word_cur  = frame_start ? 5'd0 : word_cnt_q;
	assign good_cur  = frame_start ? 5'd0 : good_cnt_q;
	assign fail_cur  = frame_start ? 5'd0 : fail_cnt_q;

	assign is_crc = (phase_cur == PH_CRC) || (phase_cur == PH_SPARE);

	always_comb begin
		if (words_cfg == 5'd0) begin
			words_eff = 5'd1;
		end else if (words_cfg > WORDS_MAX) begin
			words_eff = WORDS_MAX;
		end else begin
			words_eff = words_cfg;
		end
	end

	assign ok       = (crc_q == rx_byte);
	assign good_nxt = (ok && good_cur < COUNT_MAX) ? good_cur + 5'd1 : good_cur;
	assign fail_nxt = (!ok && fail_cur < COUNT_MAX) ? fail_cur + 5'd1 : fail_cur;
	assign word_nxt = (word_cur < COUNT_MAX) ? word_cur + 5'd1 : word_cur;
	assign last     = (word_nxt >= words_eff);

	always_comb begin
		res_valid       = in_valid && is_crc;
		res.data_word   = {high_q, low_q};
		res.crc_ok      = ok;
		res.store_index = ok ? good_cur[3:0] : 4'd0;
		res.word_last   = last;
		res.all_ok      = last && (fail_nxt == 5'd0);
		res.error_count = fail_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HIGH;
			crc_q      <= 8'h00;
			high_q     <= 8'h00;
			low_q      <= 8'h00;
			word_cnt_q <= 5'd0;
			good_cnt_q <= 5'd0;
			fail_cnt_q <= 5'd0;
		end else if (in_valid) begin
			case (phase_cur)
				PH_HIGH: begin
					high_q     <= rx_byte;
					crc_q      <= crc8_step(CRC_INIT, rx_byte);
					phase_q    <= PH_LOW;
					word_cnt_q <= word_cur;
					good_cnt_q <= good_cur;
					fail_cnt_q <= fail_cur;
				end
				PH_LOW: begin
					low_q   <= rx_byte;
					crc_q   <= crc8_step(crc_q, rx_byte);
					phase_q <= PH_CRC;
				end
				default: begin
					phase_q <= PH_HIGH;
					if (last) begin
						word_cnt_q <= 5'd0;
						good_cnt_q <= 5'd0;
						fail_cnt_q <= 5'd0;
					end else begin
						word_cnt_q <= word_nxt;
						good_cnt_q <= good_nxt;
						fail_cnt_q <= fail_nxt;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: design/crc8dfc_skid.sv
`default_nettype none

module crc8dfc_skid
	import crc8dfc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire result_t in_res,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      out_res
);

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic    main_load;

	// The main register reloads when it is empty or being taken this cycle.
	assign main_load = !main_valid_q || out_ready;
	assign in_ready  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_res   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_load) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= in_valid;
			end
		end else if (in_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_load) begin
			main_q <= skid_valid_q ? skid_q : in_res;
		end else if (in_valid) begin
			skid_q <= in_res;
		end
	end

endmodule

`default_nettype wire
